// ===== rtl/bdpc_pkg.sv =====
// Package for the button debounce and press classifier.
// Holds the word types, the button state and event codes, and register indexes.
// Depends on nothing.
`default_nettype none

package bdpc_pkg;

  localparam int ButtonW = 2;
  localparam int TimeW   = 32;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 1;

  typedef enum logic [2:0] {
    ST_RELEASED = 3'b001,
    ST_PRESSED  = 3'b010,
    ST_INVALID  = 3'b100
  } btn_state_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } ev_code_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } cfg_reg_t;

  localparam logic [CfgW-1:0] DebounceReset  = 16'd50;
  localparam logic [CfgW-1:0] LongPressReset = 16'd5000;

  typedef struct packed {
    logic [ButtonW-1:0] button;
    logic [TimeW-1:0]   time_ms;
  } in_word_t;

  typedef struct packed {
    ev_code_t           event_code;
    logic [ButtonW-1:0] event_button;
  } out_word_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
  } cfg_t;

  // Update command from the classifier to every button lane.
  typedef struct packed {
    logic       write;
    btn_state_t wr_state;
    logic       invalidate;
  } lane_upd_t;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_press_classifier.sv =====
// Top level of the button debounce and short/long press classifier.
// Depends on bdpc_pkg, bdpc_cfg and bdpc_lane.
//
//   channel | handshake              | word
//   --------+------------------------+-------------------------------
//   in      | in_valid / in_stall    | in_data  (button, time_ms)
//   out     | out_valid / out_stall  | out_data (event_code, event_button)
//   cfg     | cfg_we                 | cfg_index, cfg_data
//
// One word per cycle unless out_stall holds it; results come from the output register.
// Lane state is read and written in the same stage, so consecutive words see each
// other's updates without bubbles. The output register holds a stalled result while
// one more word waits in the input register. Synchronous reset clears all buttons to
// released with time zero and loads the default debounce and long-press times.
`default_nettype none

module button_debounce_press_classifier #(
  parameter int NUM_BUTTONS = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bdpc_pkg::in_word_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bdpc_pkg::out_word_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [bdpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [bdpc_pkg::CfgW-1:0]     cfg_data
);

  localparam int IdxW  = $clog2(NUM_BUTTONS);
  localparam int LaneW = (IdxW > bdpc_pkg::ButtonW) ? IdxW : bdpc_pkg::ButtonW;

  bdpc_pkg::cfg_t       cfg;
  bdpc_pkg::in_word_t   s1_data;
  logic                 s1_valid;
  logic                 in_accept;
  logic                 advance;

  logic [LaneW-1:0]             button_ext;
  logic [NUM_BUTTONS-1:0]       hit;
  bdpc_pkg::btn_state_t         lane_state [NUM_BUTTONS];
  logic [bdpc_pkg::TimeW-1:0]   lane_time  [NUM_BUTTONS];
  logic [2:0]                   sel_state;
  logic [bdpc_pkg::TimeW-1:0]   sel_time;
  logic [bdpc_pkg::TimeW-1:0]   elapsed;
  logic                         bounce;
  logic                         is_long;
  logic                         do_write;
  logic                         do_release;
  bdpc_pkg::btn_state_t         wr_state;
  bdpc_pkg::ev_code_t           ev;
  bdpc_pkg::lane_upd_t          upd;

  bdpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the input register advances whenever the output register frees up.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data <= in_data;
    end
  end

  assign button_ext = LaneW'(s1_data.button);

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    assign hit[i] = (button_ext == LaneW'(i));

    bdpc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .hit       (hit[i]),
      .time_ms   (s1_data.time_ms),
      .upd       (upd),
      .state     (lane_state[i]),
      .edge_time (lane_time[i])
    );
  end

  // Select the addressed lane; hit is one-hot or zero for an index out of range.
  always_comb begin
    sel_state = '0;
    sel_time  = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (hit[i]) begin
        sel_state = sel_state | lane_state[i];
        sel_time  = sel_time | lane_time[i];
      end
    end
  end

  assign elapsed = s1_data.time_ms - sel_time;
  assign bounce  = elapsed < {{(bdpc_pkg::TimeW - bdpc_pkg::CfgW){1'b0}}, cfg.debounce_ms};
  assign is_long = elapsed >= {{(bdpc_pkg::TimeW - bdpc_pkg::CfgW){1'b0}}, cfg.long_press_ms};

  always_comb begin
    do_write   = 1'b0;
    do_release = 1'b0;
    wr_state   = bdpc_pkg::ST_RELEASED;
    ev         = bdpc_pkg::EV_NONE;
    if (|hit) begin
      unique case (sel_state)
        bdpc_pkg::ST_INVALID: begin
          // swallow the edge and rearm
          do_write = 1'b1;
        end
        bdpc_pkg::ST_RELEASED: begin
          if (!bounce) begin
            do_write = 1'b1;
            wr_state = bdpc_pkg::ST_PRESSED;
          end
        end
        bdpc_pkg::ST_PRESSED: begin
          if (!bounce) begin
            do_write   = 1'b1;
            do_release = 1'b1;
            ev         = is_long ? bdpc_pkg::EV_LONG : bdpc_pkg::EV_SHORT;
          end
        end
        default: ;
      endcase
    end
  end

  assign upd.write      = advance && do_write;
  assign upd.wr_state   = wr_state;
  assign upd.invalidate = advance && do_release;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.event_code   <= ev;
      out_data.event_button <= s1_data.button;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdpc_cfg.sv =====
// Configuration registers: debounce time and long-press threshold.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [bdpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [bdpc_pkg::CfgW-1:0]       cfg_data,
  output bdpc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= bdpc_pkg::DebounceReset;
      cfg.long_press_ms <= bdpc_pkg::LongPressReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdpc_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data;
        bdpc_pkg::REG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdpc_lane.sv =====
// One button lane: its state and the time of its last accepted edge.
// Depends on bdpc_pkg.
`default_nettype none

module bdpc_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           hit,
  input  wire logic [bdpc_pkg::TimeW-1:0]     time_ms,
  input  wire bdpc_pkg::lane_upd_t            upd,
  output bdpc_pkg::btn_state_t                state,
  output logic [bdpc_pkg::TimeW-1:0]          edge_time
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdpc_pkg::ST_RELEASED;
      edge_time <= '0;
    end else if (upd.write && hit) begin
      state     <= upd.wr_state;
      edge_time <= time_ms;
    end else if (upd.invalidate && !hit && state == bdpc_pkg::ST_PRESSED) begin
      // another button was released while this one was held
      state <= bdpc_pkg::ST_INVALID;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdpc_checker.sv =====
// Port-level checks for the button debounce and press classifier, bound to the top.
// Depends on bdpc_pkg and button_debounce_press_classifier.
`default_nettype none

module bdpc_checker #(
  parameter int NUM_BUTTONS = 3
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bdpc_pkg::out_word_t out_data
);

  localparam int CmpW = (bdpc_pkg::ButtonW > 5) ? bdpc_pkg::ButtonW + 1 : 6;

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An empty output register never backs up the input.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A taken word moves on from the input to the output register when the output is free.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result missing after accepted word");

  // A button index beyond the lanes never reports a press.
  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (CmpW'(out_data.event_button) >= CmpW'(NUM_BUTTONS))
      |-> out_data.event_code == bdpc_pkg::EV_NONE)
    else $error("event on out-of-range button");

endmodule

bind button_debounce_press_classifier bdpc_checker #(
  .NUM_BUTTONS (NUM_BUTTONS)
) u_bdpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/button_debounce_press_classifier_test.sv =====
`timescale 1ns / 1ps
// Testbench for button_debounce_press_classifier: directed and random edge words are
// checked field by field against a press classifier kept inside the bench.
// Depends on bdpc_pkg and the RTL of the block.

module button_debounce_press_classifier_test;

  localparam int NumBtn     = 3;
  localparam int IdleLimit  = 4000;
  localparam int HoldCycles = 300;

  logic                         clk;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  bdpc_pkg::in_word_t           in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  bdpc_pkg::out_word_t          out_data;
  logic                         cfg_we    = 1'b0;
  logic [bdpc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [bdpc_pkg::CfgW-1:0]    cfg_data  = '0;

  button_debounce_press_classifier #(.NUM_BUTTONS(NumBtn)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Classifier state mirrored in the bench.
  bdpc_pkg::btn_state_t         press_state [NumBtn];
  logic [bdpc_pkg::TimeW-1:0]   last_edge_ms [NumBtn];
  logic [bdpc_pkg::CfgW-1:0]    debounce_cfg   = bdpc_pkg::DebounceReset;
  logic [bdpc_pkg::CfgW-1:0]    long_press_cfg = bdpc_pkg::LongPressReset;

  bdpc_pkg::in_word_t    pending_edges [$];
  bdpc_pkg::out_word_t   expected_events [$];
  int unsigned edges_queued = 0;
  int unsigned events_seen  = 0;
  int unsigned err_count    = 0;

  function automatic bdpc_pkg::out_word_t classify_edge(input bdpc_pkg::in_word_t w);
    bdpc_pkg::out_word_t        ev;
    logic [bdpc_pkg::TimeW-1:0] held;
    ev.event_code   = bdpc_pkg::EV_NONE;
    ev.event_button = w.button;
    if (w.button < NumBtn) begin
      held = w.time_ms - last_edge_ms[w.button];
      if (press_state[w.button] == bdpc_pkg::ST_INVALID) begin
        press_state[w.button]  = bdpc_pkg::ST_RELEASED;
        last_edge_ms[w.button] = w.time_ms;
      end else if (held < debounce_cfg) begin
        // bounce: drop, keep state and time
      end else if (press_state[w.button] == bdpc_pkg::ST_RELEASED) begin
        press_state[w.button]  = bdpc_pkg::ST_PRESSED;
        last_edge_ms[w.button] = w.time_ms;
      end else begin
        if (held < long_press_cfg) begin
          ev.event_code = bdpc_pkg::EV_SHORT;
        end else begin
          ev.event_code = bdpc_pkg::EV_LONG;
        end
        press_state[w.button]  = bdpc_pkg::ST_RELEASED;
        last_edge_ms[w.button] = w.time_ms;
        // a release spoils every other button held at the same time
        for (int i = 0; i < NumBtn; i++) begin
          if (i != w.button && press_state[i] == bdpc_pkg::ST_PRESSED) begin
            press_state[i] = bdpc_pkg::ST_INVALID;
          end
        end
      end
    end
    return ev;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_edge(input logic [bdpc_pkg::ButtonW-1:0] b,
                          input logic [bdpc_pkg::TimeW-1:0] t);
    bdpc_pkg::in_word_t w;
    w.button  = b;
    w.time_ms = t;
    pending_edges.push_back(w);
    edges_queued++;
  endtask

  task automatic set_reg(input bdpc_pkg::cfg_reg_t idx, input logic [bdpc_pkg::CfgW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bdpc_pkg::REG_DEBOUNCE) begin
      debounce_cfg = val;
    end else begin
      long_press_cfg = val;
    end
  endtask

  task automatic wait_drained();
    while (pending_edges.size() != 0 || in_valid || expected_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Mostly press/hold/release sequences with bounces and a second button held down;
  // the rest is loose noise, including the out-of-range index.
  task automatic run_phase(input logic [bdpc_pkg::CfgW-1:0] deb,
                           input logic [bdpc_pkg::CfgW-1:0] lng,
                           input logic [bdpc_pkg::TimeW-1:0] start_ms,
                           input int unsigned count);
    logic [bdpc_pkg::TimeW-1:0]   now_ms;
    logic [bdpc_pkg::TimeW-1:0]   t_press;
    logic [bdpc_pkg::TimeW-1:0]   t_rel;
    logic [bdpc_pkg::TimeW-1:0]   hold;
    logic [bdpc_pkg::ButtonW-1:0] b;
    logic [bdpc_pkg::ButtonW-1:0] b2;
    bit                           two_down;
    int unsigned                  goal;
    set_reg(bdpc_pkg::REG_DEBOUNCE, deb);
    set_reg(bdpc_pkg::REG_LONG_PRESS, lng);
    now_ms = start_ms;
    goal   = edges_queued + count;
    while (edges_queued < goal) begin
      if ($urandom_range(0, 9) < 8) begin
        b        = bdpc_pkg::ButtonW'($urandom_range(0, NumBtn - 1));
        b2       = bdpc_pkg::ButtonW'((b + $urandom_range(1, NumBtn - 1)) % NumBtn);
        two_down = ($urandom_range(0, 2) == 0);
        t_press  = now_ms + deb + $urandom_range(0, 30);
        add_edge(b, t_press);
        if (two_down) begin
          add_edge(b2, t_press + $urandom_range(0, 100));
        end
        if (deb != 0) begin
          repeat ($urandom_range(0, 3)) add_edge(b, t_press + $urandom_range(0, deb - 1));
        end
        case ($urandom_range(0, 4))
          0: hold = $urandom_range(0, lng);
          1: hold = lng + $urandom_range(0, 4) - 2;
          2: hold = deb + $urandom_range(0, 4) - 2;
          3: hold = $urandom;
          default: hold = $urandom_range(0, 3 * lng + 100);
        endcase
        t_rel = t_press + hold;
        add_edge(b, t_rel);
        if (deb != 0) begin
          repeat ($urandom_range(0, 2)) add_edge(b, t_rel + $urandom_range(0, deb - 1));
        end
        if (two_down && $urandom_range(0, 1) == 1) begin
          add_edge(b2, t_rel + $urandom_range(1, 100));
        end
        now_ms = t_rel + deb + $urandom_range(101, 300);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 1) begin
            add_edge(bdpc_pkg::ButtonW'($urandom_range(0, 3)), $urandom);
          end else begin
            add_edge(bdpc_pkg::ButtonW'($urandom_range(0, 3)),
                     now_ms + $urandom_range(0, 200));
          end
        end
      end
    end
    wait_drained();
  endtask

  // Driver: bursts of words with random gaps; hold the word while stalled.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_events.push_back(classify_edge(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (burst_left != 0 && pending_edges.size() != 0) begin
          in_data    <= pending_edges.pop_front();
          in_valid   <= 1'b1;
          burst_left = burst_left - 1;
        end else begin
          in_valid <= 1'b0;
          if (burst_left == 0) begin
            if (gap_left != 0) begin
              gap_left = gap_left - 1;
            end else if ($urandom_range(0, 4) == 0) begin
              burst_left = $urandom_range(40, 120);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(1, 6);
            end
          end
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus long hold-offs.
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 300;
  int unsigned mode_left    = 0;
  int unsigned stall_mode   = 0;
  bit          next_stall;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        next_stall = 1'b1;
        hold_left  = hold_left - 1;
      end else if (events_seen >= next_hold_at) begin
        next_stall   = 1'b1;
        hold_left    = HoldCycles;
        next_hold_at = next_hold_at + 750;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 200);
        end else begin
          mode_left = mode_left - 1;
        end
        case (stall_mode)
          0: next_stall = 1'b0;
          1: next_stall = ($urandom_range(0, 3) == 0);
          2: next_stall = ($urandom_range(0, 3) != 0);
          default: next_stall = ~out_stall;
        endcase
      end
      out_stall <= next_stall;
    end
  end

  // Monitor: compare each taken result word with the oldest expectation.
  bdpc_pkg::out_word_t want_event;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        flag_error($sformatf("result word %h with nothing expected", out_data));
      end else begin
        want_event = expected_events.pop_front();
        if (out_data.event_code !== want_event.event_code) begin
          flag_error($sformatf("result %0d: event_code %0d, expected %0d", events_seen,
                               out_data.event_code, want_event.event_code));
        end
        if (out_data.event_button !== want_event.event_button) begin
          flag_error($sformatf("result %0d: event_button %0d, expected %0d", events_seen,
                               out_data.event_button, want_event.event_button));
        end
      end
      events_seen <= events_seen + 1;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumBtn; i++) begin
      press_state[i]  = bdpc_pkg::ST_RELEASED;
      last_edge_ms[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset times still in force: bounce against time zero, thresholds hit exactly,
    // a second button spoiled by a release, out-of-range index, wrap of the tick.
    add_edge(2'd0, 32'd0);
    add_edge(2'd0, 32'd100);
    add_edge(2'd0, 32'd120);
    add_edge(2'd0, 32'd5099);
    add_edge(2'd1, 32'd6000);
    add_edge(2'd2, 32'd6010);
    add_edge(2'd1, 32'd11000);
    add_edge(2'd2, 32'd11001);
    add_edge(2'd2, 32'd11020);
    add_edge(2'd2, 32'd11051);
    add_edge(2'd3, 32'd0);
    add_edge(2'd3, 32'hFFFF_FFFF);
    add_edge(2'd2, 32'hFFFF_FFFF);
    add_edge(2'd0, 32'hFFFF_FFF0);
    add_edge(2'd0, 32'h0000_0020);
    add_edge(2'd0, 32'h0000_1380);
    wait_drained();

    // Zero debounce and zero threshold: a zero-length press is a long press.
    set_reg(bdpc_pkg::REG_DEBOUNCE, 16'd0);
    set_reg(bdpc_pkg::REG_LONG_PRESS, 16'd0);
    add_edge(2'd1, 32'd11000);
    add_edge(2'd1, 32'd11000);
    wait_drained();

    // Both times at their maximum.
    set_reg(bdpc_pkg::REG_DEBOUNCE, 16'hFFFF);
    set_reg(bdpc_pkg::REG_LONG_PRESS, 16'hFFFF);
    add_edge(2'd0, 32'h0000_1380 + 32'd65534);
    add_edge(2'd0, 32'h0000_1380 + 32'd65535);
    add_edge(2'd0, 32'h0000_1380 + 32'd131069);
    wait_drained();

    run_phase(bdpc_pkg::DebounceReset, bdpc_pkg::LongPressReset, $urandom, 400);
    run_phase(16'd0, 16'd0, $urandom, 250);
    run_phase(16'hFFFF, 16'hFFFF, $urandom, 250);
    run_phase(16'd1, 16'd1, 32'hFFFF_0000, 250);
    repeat (3) begin
      run_phase(bdpc_pkg::CfgW'($urandom_range(0, 300)),
                bdpc_pkg::CfgW'($urandom_range(0, 20000)), $urandom, 280);
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== button_debounce_press_classifier.f =====
rtl/bdpc_pkg.sv
rtl/bdpc_cfg.sv
rtl/bdpc_lane.sv
rtl/button_debounce_press_classifier.sv
rtl/bdpc_checker.sv
verif/button_debounce_press_classifier_test.sv
